// ===== rtl/core/lmfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lmfr_pkg
// shared types and constants of the led matrix frame refresh unit
// ----------------------------------------------------------------------------
package lmfr_pkg;

	localparam int ADDR_W     = 7;   // covers the largest store of 72 bytes
	localparam int MOD_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [7:0] DIGIT_BASE = 8'h01;
	localparam logic [7:0] TOP_BIT    = 8'h80;
	localparam logic [7:0] LOW_BIT    = 8'h01;

	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_270 = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODULE_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_SHIFT     = 2'd3;

	typedef enum logic [2:0] {
		CMD_WRITE    = 3'd0,
		CMD_LOAD     = 3'd1,
		CMD_SCROLL   = 3'd2,
		CMD_CLEAR    = 3'd3,
		CMD_INVERT   = 3'd4,
		CMD_REFRESH  = 3'd5,
		CMD_SEND_ONE = 3'd6,
		CMD_SEND_ALL = 3'd7
	} cmd_e_t;

	typedef enum logic [1:0] {
		WSEL_VALUE,
		WSEL_OR,
		WSEL_COPY,
		WSEL_INV
	} wsel_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_BYTE,
		ACC_BIT
	} acc_t;

	typedef enum logic [1:0] {
		OSEL_REFRESH,
		OSEL_ONE,
		OSEL_ALL
	} osel_t;

	// controller to datapath
	typedef struct packed {
		logic              take;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		wsel_t             wsel;
		logic              clr;
		acc_t              acc;
		logic [2:0]        acc_b;
		logic [2:0]        acc_digit;
		logic              ld_out;
		osel_t             osel;
		logic [2:0]        out_digit;
		logic [MOD_W-1:0]  mod_idx;
		logic              latch;
		logic              last;
	} lmfr_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_e_t            cmd;
		logic              wr_ok;
		logic              ld_ok;
		logic              shift_zero;
		logic [ADDR_W-1:0] tgt_addr;
		logic [ADDR_W-1:0] tail_addr;
		logic [3:0]        mods;
		logic [1:0]        rotation;
		logic              out_free;
	} lmfr_status_t;

endpackage

// ===== rtl/core/led_matrix_frame_refresh_unit.sv =====
// ----------------------------------------------------------------------------
// led_matrix_frame_refresh_unit
// column frame buffer and word generator for a chain of 8x8 led matrix drivers
// ----------------------------------------------------------------------------
// One command beat is taken at a time; the slave side is ready only while the
// sequencer is idle. The store holds one byte per visible column (8 per module
// in use) plus an 8-column scroll tail, in a single-port-read memory with a
// registered read and a valid bit per entry, so it reads as zero after reset
// with no clearing pass. Write column reads the stored byte first when the
// row shift ORs into it; invert and scroll left sweep the store one stored
// column per cycle through the read port; send one/send all emit one word
// per module in use. An unrotated refresh word is one stored byte, while
// each rotated word gathers its byte from the 8 stored columns of its module,
// one memory read per cycle, so the single read port sets the refresh time.
// Words go out highest module first; tuser carries the latch flag, which
// marks each word of module 0, and tlast the final word of a command.
// ----------------------------------------------------------------------------
module led_matrix_frame_refresh_unit import lmfr_pkg::*; #(
	parameter int MAX_MODULES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// command beats
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // column[7:0], value[15:8],
	                                         // module_req[18:16],
	                                         // register_address[26:19], zero[31:27]
	input  logic [2:0]            s_tuser,   // command[2:0]
	// driver words
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // reg_address[7:0], reg_data[15:8]
	output logic                  m_tuser,   // latch[0]
	output logic                  m_tlast    // final word of the command
);

	// sequencer commands and datapath status
	lmfr_cmd_t    cmd;
	lmfr_status_t status;

	lmfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lmfr_datapath #(
		.MAX_MODULES (MAX_MODULES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

// ===== rtl/core/lmfr_datapath.sv =====
// ----------------------------------------------------------------------------
// lmfr_datapath
// config registers, item latch, column store with valid bits, gather
// accumulator and output word register
// ----------------------------------------------------------------------------
module lmfr_datapath import lmfr_pkg::*; #(
	parameter int MAX_MODULES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [31:0]           s_tdata,
	input  logic [2:0]            s_tuser,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [15:0]           m_tdata,
	output logic                  m_tuser,
	output logic                  m_tlast,
	input  lmfr_cmd_t             cmd,
	output lmfr_status_t          status
);

	localparam int DEPTH = MAX_MODULES * 8 + 8;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [3:0] MOD_MAX = 4'(MAX_MODULES);

	logic [3:0]        module_count_q;
	logic [1:0]        rotation_q;
	logic signed [6:0] column_offset_q;
	logic signed [4:0] row_shift_q;

	cmd_e_t            cmd_q;
	logic [7:0]        col_q;
	logic [7:0]        value_q;
	logic [MOD_W-1:0]  req_q;
	logic [7:0]        ra_q;

	logic [7:0]        mem_q [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [7:0]        rdata_s1;
	logic              rvalid_s1;
	logic [7:0]        rd_data;
	logic [7:0]        wr_data;

	logic [7:0]        acc_q;
	logic              out_valid_q;
	logic [7:0]        out_addr_q;
	logic [7:0]        out_data_q;
	logic              out_latch_q;
	logic              out_last_q;

	logic [3:0]        mods;
	logic [ADDR_W-1:0] vis;
	logic [8:0]        tgt_sum;
	logic              shift_ok;
	logic [4:0]        shift_mag;
	logic [15:0]       shift_left;
	logic [7:0]        shifted;
	logic [7:0]        bit_mask;
	logic [2:0]        bit_pos;
	logic              hit;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_count_q  <= 4'd4;
			rotation_q      <= 2'd0;
			column_offset_q <= '0;
			row_shift_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODULE_COUNT:  module_count_q  <= cfg_wdata[3:0];
				CFG_ROTATION:      rotation_q      <= cfg_wdata[1:0];
				CFG_COLUMN_OFFSET: column_offset_q <= cfg_wdata[6:0];
				CFG_ROW_SHIFT:     row_shift_q     <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q   <= cmd_e_t'(s_tuser);
			col_q   <= s_tdata[7:0];
			value_q <= s_tdata[15:8];
			req_q   <= s_tdata[18:16];
			ra_q    <= s_tdata[26:19];
		end
	end

	always_comb begin
		if (module_count_q == 4'd0) begin
			mods = 4'd1;
		end else if (module_count_q > MOD_MAX) begin
			mods = MOD_MAX;
		end else begin
			mods = module_count_q;
		end
	end

	assign vis      = {mods, 3'b000};
	assign tgt_sum  = {col_q[7], col_q} + {{2{column_offset_q[6]}}, column_offset_q};
	assign shift_ok = (row_shift_q >= -5'sd8) && (row_shift_q <= 5'sd8);

	assign shift_mag  = row_shift_q[4] ? 5'(-row_shift_q) : row_shift_q;
	assign shift_left = {8'd0, value_q} << shift_mag;
	assign shifted    = row_shift_q[4] ? shift_left[7:0] : (value_q >> shift_mag);

	// column store, unwritten entries read as zero through the valid bits
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[cmd.wr_addr[AW-1:0]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem_q[cmd.rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (cmd.clr) begin
				for (int i = 0; i < DEPTH; i++) begin
					if (ADDR_W'(i) < vis) begin
						valid_q[i] <= 1'b0;
					end
				end
			end
			if (cmd.wr_en) begin
				valid_q[cmd.wr_addr[AW-1:0]] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rvalid_s1 <= valid_q[cmd.rd_addr[AW-1:0]];
			end
		end
	end

	assign rd_data = rvalid_s1 ? rdata_s1 : 8'd0;

	always_comb begin
		case (cmd.wsel)
			WSEL_VALUE: wr_data = value_q;
			WSEL_OR:    wr_data = rd_data | shifted;
			WSEL_COPY:  wr_data = rd_data;
			WSEL_INV:   wr_data = ~rd_data;
			default:    wr_data = value_q;
		endcase
	end

	// transpose gather, one stored byte per cycle
	assign bit_mask = (rotation_q == ROT_90) ? (TOP_BIT >> cmd.acc_digit)
	                                         : (LOW_BIT << cmd.acc_digit);
	assign bit_pos  = (rotation_q == ROT_90) ? cmd.acc_b : ~cmd.acc_b;

	always_ff @(posedge clk) begin
		case (cmd.acc)
			ACC_BYTE: acc_q <= rd_data;
			ACC_BIT:  acc_q[bit_pos] <= |(rd_data & bit_mask);
			default: ;
		endcase
	end

	// output word register
	assign hit = (cmd.mod_idx == req_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_latch_q <= cmd.latch;
			out_last_q  <= cmd.last;
			case (cmd.osel)
				OSEL_REFRESH: begin
					out_addr_q <= DIGIT_BASE + {5'd0, cmd.out_digit};
					out_data_q <= acc_q;
				end
				OSEL_ONE: begin
					out_addr_q <= hit ? ra_q : 8'd0;
					out_data_q <= hit ? value_q : 8'd0;
				end
				default: begin
					out_addr_q <= ra_q;
					out_data_q <= value_q;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_data_q, out_addr_q};
	assign m_tuser  = out_latch_q;
	assign m_tlast  = out_last_q;

	assign status.cmd        = cmd_q;
	assign status.wr_ok      = shift_ok && !tgt_sum[8] && (tgt_sum[7:0] < {1'b0, vis});
	assign status.ld_ok      = (col_q[7:3] == 5'd0);
	assign status.shift_zero = (row_shift_q == 5'sd0);
	assign status.tgt_addr   = tgt_sum[ADDR_W-1:0];
	assign status.tail_addr  = vis + {4'd0, col_q[2:0]};
	assign status.mods       = mods;
	assign status.rotation   = rotation_q;
	assign status.out_free   = !out_valid_q || m_tready;

endmodule

// ===== rtl/core/lmfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lmfr_ctrl
// command sequencer: decodes one item, walks the store and paces the words
// ----------------------------------------------------------------------------
module lmfr_ctrl import lmfr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  lmfr_status_t status,
	output lmfr_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WCOL,
		ST_SWEEP,
		ST_GATHER,
		ST_DRAIN,
		ST_EMIT,
		ST_SEND
	} state_t;

	state_t            state_q;
	logic              rd_en_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic              wr_en_q;
	logic [ADDR_W-1:0] wr_addr_q;
	wsel_t             wsel_q;
	logic              clr_q;
	logic              rd_acc_q;
	logic [2:0]        rd_b_q;
	acc_t              acc_q;
	logic [2:0]        acc_b_q;
	logic              ld_out_q;
	osel_t             osel_q;
	logic [2:0]        out_digit_q;
	logic [MOD_W-1:0]  out_mod_q;
	logic              out_latch_q;
	logic              out_last_q;
	logic [ADDR_W-1:0] j_q;
	logic [ADDR_W-1:0] last_q;
	logic [2:0]        c_q;
	logic [MOD_W-1:0]  i_q;
	logic [2:0]        b_q;

	logic              rot_plain;
	logic [ADDR_W-1:0] vis;
	logic [MOD_W-1:0]  mtop;
	logic              out_free;

	assign rot_plain = !(status.rotation == ROT_90 || status.rotation == ROT_270);
	assign vis       = {status.mods, 3'b000};
	assign mtop      = MOD_W'(status.mods - 4'd1);
	assign out_free  = status.out_free && !ld_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_en_q     <= 1'b0;
			rd_addr_q   <= '0;
			wr_en_q     <= 1'b0;
			wr_addr_q   <= '0;
			wsel_q      <= WSEL_VALUE;
			clr_q       <= 1'b0;
			rd_acc_q    <= 1'b0;
			rd_b_q      <= '0;
			acc_q       <= ACC_NONE;
			acc_b_q     <= '0;
			ld_out_q    <= 1'b0;
			osel_q      <= OSEL_REFRESH;
			out_digit_q <= '0;
			out_mod_q   <= '0;
			out_latch_q <= 1'b0;
			out_last_q  <= 1'b0;
			j_q         <= '0;
			last_q      <= '0;
			c_q         <= '0;
			i_q         <= '0;
			b_q         <= '0;
		end else begin
			rd_en_q  <= 1'b0;
			wr_en_q  <= 1'b0;
			clr_q    <= 1'b0;
			ld_out_q <= 1'b0;
			rd_acc_q <= 1'b0;
			acc_q    <= rd_acc_q ? (rot_plain ? ACC_BYTE : ACC_BIT) : ACC_NONE;
			acc_b_q  <= rd_b_q;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_IDLE;
					case (status.cmd)
						CMD_WRITE: begin
							wr_addr_q <= status.tgt_addr;
							rd_addr_q <= status.tgt_addr;
							if (status.wr_ok && status.shift_zero) begin
								wr_en_q <= 1'b1;
								wsel_q  <= WSEL_VALUE;
							end else if (status.wr_ok) begin
								rd_en_q <= 1'b1;
								wsel_q  <= WSEL_OR;
								state_q <= ST_WCOL;
							end
						end
						CMD_LOAD: begin
							wr_en_q   <= status.ld_ok;
							wr_addr_q <= status.tail_addr;
							wsel_q    <= WSEL_VALUE;
						end
						CMD_SCROLL: begin
							rd_en_q   <= 1'b1;
							rd_addr_q <= ADDR_W'(1);
							j_q       <= '0;
							last_q    <= vis + ADDR_W'(6);
							wsel_q    <= WSEL_COPY;
							state_q   <= ST_SWEEP;
						end
						CMD_INVERT: begin
							rd_en_q   <= 1'b1;
							rd_addr_q <= '0;
							j_q       <= '0;
							last_q    <= vis - ADDR_W'(1);
							wsel_q    <= WSEL_INV;
							state_q   <= ST_SWEEP;
						end
						CMD_CLEAR: begin
							clr_q <= 1'b1;
						end
						CMD_REFRESH: begin
							c_q     <= '0;
							i_q     <= mtop;
							b_q     <= '0;
							state_q <= ST_GATHER;
						end
						CMD_SEND_ONE, CMD_SEND_ALL: begin
							i_q     <= mtop;
							state_q <= ST_SEND;
						end
						default: ;
					endcase
				end
				ST_WCOL: begin
					wr_en_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					wr_en_q   <= 1'b1;
					wr_addr_q <= j_q;
					if (j_q != last_q) begin
						j_q       <= j_q + ADDR_W'(1);
						rd_en_q   <= 1'b1;
						rd_addr_q <= rd_addr_q + ADDR_W'(1);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_GATHER: begin
					rd_en_q   <= 1'b1;
					rd_acc_q  <= 1'b1;
					rd_b_q    <= b_q;
					rd_addr_q <= rot_plain ? {1'b0, i_q, c_q} : {1'b0, i_q, b_q};
					if (rot_plain || b_q == 3'd7) begin
						b_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						b_q <= b_q + 3'd1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						ld_out_q    <= 1'b1;
						osel_q      <= OSEL_REFRESH;
						out_digit_q <= c_q;
						out_mod_q   <= i_q;
						out_latch_q <= (i_q == '0);
						out_last_q  <= (i_q == '0) && (c_q == 3'd7);
						if (i_q != '0) begin
							i_q     <= i_q - MOD_W'(1);
							state_q <= ST_GATHER;
						end else if (c_q != 3'd7) begin
							c_q     <= c_q + 3'd1;
							i_q     <= mtop;
							state_q <= ST_GATHER;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SEND: begin
					if (out_free) begin
						ld_out_q    <= 1'b1;
						osel_q      <= (status.cmd == CMD_SEND_ONE) ? OSEL_ONE : OSEL_ALL;
						out_mod_q   <= i_q;
						out_latch_q <= (i_q == '0);
						out_last_q  <= (i_q == '0);
						if (i_q != '0) begin
							i_q <= i_q - MOD_W'(1);
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	assign cmd.take      = s_tvalid && (state_q == ST_IDLE);
	assign cmd.rd_en     = rd_en_q;
	assign cmd.rd_addr   = rd_addr_q;
	assign cmd.wr_en     = wr_en_q;
	assign cmd.wr_addr   = wr_addr_q;
	assign cmd.wsel      = wsel_q;
	assign cmd.clr       = clr_q;
	assign cmd.acc       = acc_q;
	assign cmd.acc_b     = acc_b_q;
	assign cmd.acc_digit = c_q;
	assign cmd.ld_out    = ld_out_q;
	assign cmd.osel      = osel_q;
	assign cmd.out_digit = out_digit_q;
	assign cmd.mod_idx   = out_mod_q;
	assign cmd.latch     = out_latch_q;
	assign cmd.last      = out_last_q;

`ifndef SYNTHESIS
	// a read and a write of the store never hit the same entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en_q && wr_en_q |-> rd_addr_q != wr_addr_q)
		else $error("store read and write at the same address");

	// output loads are spaced so the word register is never overrun
	a_ld_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out_q |=> !ld_out_q)
		else $error("back to back output loads");

	// every accumulate step follows a store read
	a_acc_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q != ACC_NONE |-> $past(rd_en_q))
		else $error("accumulate without a preceding read");

	// the clear pulse stands alone
	a_clr_alone: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !wr_en_q && !rd_en_q && !ld_out_q)
		else $error("clear overlaps other store traffic");
`endif

endmodule
